[rtl/lpht_pkg.sv]
// Package for the linear-probe hash table: operation, status and slot mark codes.
// No dependencies.
package lpht_pkg;
    localparam int DEFAULT_CAPACITY = 1024;

    typedef enum logic [2:0] {
        OP_STORE   = 3'd0,
        OP_FETCH   = 3'd1,
        OP_DELETE  = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_RESTART = 3'd4,
        OP_NEXT    = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_INSERTED = 4'd0,
        ST_REPLACED = 4'd1,
        ST_FOUND    = 4'd2,
        ST_NOTFOUND = 4'd3,
        ST_DELETED  = 4'd4,
        ST_FULL     = 4'd5,
        ST_LISTED   = 4'd6,
        ST_DONE     = 4'd7,
        ST_OK       = 4'd8
    } status_t;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;
endpackage

[rtl/lpht_if.sv]
// Valid/ready channel interfaces for the hash table request and response.
// Depends on nothing.
interface lpht_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] key_in;
    logic [31:0] hash_in;
    logic [63:0] value_in;
    modport source (output valid, kind, key_in, hash_in, value_in, input ready);
    modport sink   (input valid, kind, key_in, hash_in, value_in, output ready);
endinterface

interface lpht_rsp_if #(parameter int CountWidth = 11);
    logic                  valid;
    logic                  ready;
    logic [3:0]            status;
    logic [63:0]           key_out;
    logic [63:0]           value_out;
    logic [CountWidth-1:0] entry_count;
    modport source (output valid, status, key_out, value_out, entry_count, input ready);
    modport sink   (input valid, status, key_out, value_out, entry_count, output ready);
endinterface

[rtl/lpht_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lpht_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/linear_probe_hash_table_top.sv]
// Top level of the linear-probe hash table: sequencer around slot memories.
// Depends on lpht_pkg, lpht_if and lpht_ram.
//
// Usage: requests arrive on the req channel (kind, key, hash, value); every
// request yields exactly one transaction on the rsp channel. One request is
// handled at a time. A store, fetch or delete probes one slot at a time
// (issue read, then examine registered data). Restart goes straight to the
// response. Clear sweeps every slot mark. Next entry scans slots one at a
// time from the last listed position. The probe loop through the
// single-read mark/key memory port sets the rate. After reset the block
// first sweeps the mark memory to empty and accepts no request until that
// is done. The response is held in an output register; while the receiver
// stalls the block waits and takes no further request.
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input logic       clk,
    input logic       rst_n,
    lpht_req_if.sink  req,
    lpht_rsp_if.source rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] INIT_LIMIT = CW'((CAPACITY / 3) * 2);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_READ, S_CHECK, S_RESP
    } state_t;

    state_t          state_reg;
    op_t             op_reg;
    logic [63:0]     key_reg;
    logic [31:0]     hash_reg;
    logic [63:0]     val_reg;
    logic [AW-1:0]   pos_reg;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   live_reg;
    logic [CW-1:0]   limit_reg;
    logic [AW-1:0]   walk_reg;
    logic            walk_start_reg;
    logic [3:0]      status_reg;
    logic [63:0]     kout_reg;
    logic [63:0]     vout_reg;

    // Memories: mark, and one wide row of hash/key/value.
    logic           mark_we;
    logic [AW-1:0]  mark_waddr;
    logic [1:0]     mark_wdata;
    logic [1:0]     mark_rdata;
    logic           row_we;
    logic [159:0]   row_wdata;
    logic [159:0]   row_rdata;

    lpht_ram #(.Width(2), .Depth(CAPACITY)) u_mark (
        .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
        .raddr(pos_reg), .rdata(mark_rdata)
    );
    lpht_ram #(.Width(160), .Depth(CAPACITY)) u_row (
        .clk(clk), .we(row_we), .waddr(pos_reg), .wdata(row_wdata),
        .raddr(pos_reg), .rdata(row_rdata)
    );

    logic [31:0] r_hash;
    logic [63:0] r_key;
    logic [63:0] r_val;
    logic        match;
    assign r_hash = row_rdata[159:128];
    assign r_key  = row_rdata[127:64];
    assign r_val  = row_rdata[63:0];
    assign match  = (mark_rdata == MARK_USED) && (r_hash == hash_reg) && (r_key == key_reg);

    logic          last_probe;
    assign last_probe = (n_reg == CAP_C - CW'(1));

    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = pos_reg;
        mark_wdata = MARK_EMPTY;
        row_we     = 1'b0;
        row_wdata  = {hash_reg, key_reg, val_reg};
        case (state_reg)
            S_SWEEP:
            begin
                mark_we = 1'b1;
            end
            S_CHECK:
            begin
                case (op_reg)
                    OP_STORE:
                    begin
                        if (mark_rdata != MARK_USED)
                        begin
                            mark_we    = 1'b1;
                            mark_wdata = MARK_USED;
                            row_we     = 1'b1;
                        end
                        else if (match)
                        begin
                            row_we = 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (match)
                        begin
                            mark_we    = 1'b1;
                            mark_wdata = MARK_TOMB;
                        end
                    end
                    OP_CLEAR:
                    begin
                        mark_we = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = (state_reg == S_RESP);
    assign rsp.status      = status_reg;
    assign rsp.key_out     = kout_reg;
    assign rsp.value_out   = vout_reg;
    assign rsp.entry_count = live_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            pos_reg        <= '0;
            live_reg       <= '0;
            limit_reg      <= INIT_LIMIT;
            walk_reg       <= '0;
            walk_start_reg <= 1'b1;
            n_reg          <= '0;
            op_reg         <= OP_STORE;
        end
        else
        begin
            case (state_reg)
                S_SWEEP:
                begin
                    pos_reg <= pos_reg + AW'(1);
                    if (pos_reg == AW'(CAPACITY - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg     <= op_t'(req.kind);
                        key_reg    <= req.key_in;
                        hash_reg   <= req.hash_in;
                        val_reg    <= req.value_in;
                        pos_reg    <= req.hash_in[AW-1:0];
                        n_reg      <= '0;
                        status_reg <= ST_OK;
                        kout_reg   <= '0;
                        vout_reg   <= '0;
                        case (req.kind)
                            OP_STORE:
                            begin
                                if (live_reg >= limit_reg)
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_RESP;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            OP_FETCH, OP_DELETE:
                            begin
                                state_reg <= S_READ;
                            end
                            OP_CLEAR:
                            begin
                                pos_reg   <= '0;
                                state_reg <= S_CHECK;
                            end
                            OP_RESTART:
                            begin
                                walk_start_reg <= 1'b1;
                                state_reg      <= S_RESP;
                            end
                            OP_NEXT:
                            begin
                                status_reg <= ST_DONE;
                                if (walk_start_reg)
                                begin
                                    pos_reg   <= '0;
                                    state_reg <= S_READ;
                                end
                                else if (walk_reg == AW'(CAPACITY - 1))
                                begin
                                    state_reg <= S_RESP;
                                end
                                else
                                begin
                                    pos_reg   <= walk_reg + AW'(1);
                                    state_reg <= S_READ;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    pos_reg   <= pos_reg + AW'(1);
                    n_reg     <= n_reg + CW'(1);
                    state_reg <= S_READ;
                    case (op_reg)
                        OP_STORE:
                        begin
                            if (mark_rdata != MARK_USED)
                            begin
                                if (mark_rdata == MARK_TOMB)
                                begin
                                    limit_reg <= limit_reg + CW'(1);
                                end
                                live_reg   <= live_reg + CW'(1);
                                status_reg <= ST_INSERTED;
                                state_reg  <= S_RESP;
                            end
                            else if (match)
                            begin
                                status_reg <= ST_REPLACED;
                                state_reg  <= S_RESP;
                            end
                            else if (last_probe)
                            begin
                                status_reg <= ST_FULL;
                                state_reg  <= S_RESP;
                            end
                        end
                        OP_FETCH, OP_DELETE:
                        begin
                            if (match)
                            begin
                                vout_reg <= r_val;
                                if (op_reg == OP_FETCH)
                                begin
                                    status_reg <= ST_FOUND;
                                end
                                else
                                begin
                                    status_reg <= ST_DELETED;
                                    if (live_reg != '0)
                                    begin
                                        live_reg <= live_reg - CW'(1);
                                    end
                                    if (limit_reg != '0)
                                    begin
                                        limit_reg <= limit_reg - CW'(1);
                                    end
                                end
                                state_reg <= S_RESP;
                            end
                            else if (mark_rdata == MARK_EMPTY || last_probe)
                            begin
                                status_reg <= ST_NOTFOUND;
                                state_reg  <= S_RESP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            // Sweep marks one per cycle, no read needed.
                            state_reg <= S_CHECK;
                            if (pos_reg == AW'(CAPACITY - 1))
                            begin
                                live_reg  <= '0;
                                limit_reg <= INIT_LIMIT;
                                state_reg <= S_RESP;
                            end
                        end
                        OP_NEXT:
                        begin
                            walk_start_reg <= 1'b0;
                            if (mark_rdata == MARK_USED)
                            begin
                                walk_reg   <= pos_reg;
                                status_reg <= ST_LISTED;
                                kout_reg   <= r_key;
                                vout_reg   <= r_val;
                                state_reg  <= S_RESP;
                            end
                            else if (pos_reg == AW'(CAPACITY - 1))
                            begin
                                walk_reg  <= pos_reg;
                                state_reg <= S_RESP;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_RESP;
                        end
                    endcase
                end
                S_RESP:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
